// ===== sv/rcsa_pkg.sv =====
// Shared types, constants and codes for the reference-counted slot allocator.
`default_nettype none

package rcsa_pkg;

    // Field widths of one request and one result.
    localparam int SLOT_W   = 10;
    localparam int TYPE_W   = 10;
    localparam int VALUE_W  = 32;
    localparam int LINK_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_DATA_W  = ((SLOT_W + TYPE_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SLOT_W + TYPE_W + VALUE_W + LINK_W + 7) / 8) * 8;

    // Type tag held by a free slot.
    localparam logic [TYPE_W-1:0] FREE_TYPE = TYPE_W'(206);

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Operation codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_READ    = 2'd2,
        KIND_WRITE   = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_MISMATCH = 2'd2,
        STAT_FREE     = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LOOKUP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_PUSH
    } state_t;

    // One table entry. The link count never exceeds one, so a single bit holds it.
    typedef struct packed {
        logic              used;
        logic [TYPE_W-1:0] etype;
        logic [VALUE_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic take_in;
        logic exec;
        logic lookup;
        logic scan_rd;
        logic scan_chk;
        logic push;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic alloc_full;
        logic need_scan;
        logic in_range;
        logic scan_end;
        logic scan_hit;
        logic out_free;
    } stat_t;

    // Address width for a table of the given depth.
    function automatic int addr_w(input int depth);
        addr_w = (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Width of a counter that can hold the depth itself.
    function automatic int count_w(input int depth);
        count_w = $clog2(depth + 1);
    endfunction

endpackage

`default_nettype wire

// ===== sv/rcsa_table.sv =====
// Slot table memory: one write port and one registered read port.
`default_nettype none

module rcsa_table
    import rcsa_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int AW = addr_w(TABLE_DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/rcsa_datapath.sv =====
// Datapath: request registers, allocation counters, slot table and result register.
`default_nettype none

module rcsa_datapath
    import rcsa_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [KIND_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [STATUS_W-1:0]        m_tuser
);

    localparam int AW   = addr_w(TABLE_DEPTH);
    localparam int CW   = count_w(TABLE_DEPTH);
    localparam int CMPW = ((CW > SLOT_W) ? CW : SLOT_W) + 1;
    localparam logic [CW-1:0]   DEPTH_C   = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0]   LAST_C    = CW'(TABLE_DEPTH - 1);
    localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(TABLE_DEPTH);

    localparam entry_t FREE_ENTRY = '{used: 1'b0, etype: FREE_TYPE, value: '0};

    // Request registers.
    kind_t              kind_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [TYPE_W-1:0]  ty_reg;
    logic [VALUE_W-1:0] val_reg;

    // Allocation state and the clear / scan pointer.
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] nf_reg, nf_next;
    logic [CW-1:0] ptr_reg, ptr_next;

    // Staged result.
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [TYPE_W-1:0]   res_type_reg, res_type_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic                res_link_reg, res_link_next;
    status_t             res_status_reg, res_status_next;

    // Output register.
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]   m_tuser_reg;

    // Memory port.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    logic [CMPW-1:0]   slot_ext;
    logic [CMPW-1:0]   nf_ext;
    logic [CW-1:0]     used_inc;
    logic              in_range;
    logic              slot_below_nf;
    status_t           oor_status;

    rcsa_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Address checks and derived values.
    assign slot_ext      = CMPW'(slot_reg);
    assign nf_ext        = CMPW'(nf_reg);
    assign in_range      = slot_ext < DEPTH_CMP;
    assign slot_below_nf = slot_ext < nf_ext;
    assign used_inc      = used_reg + CW'(1);

    // Status for a slot beyond the table, which reads as an empty slot.
    always_comb
    begin
        case (kind_reg)
            KIND_RELEASE: oor_status = STAT_FREE;
            KIND_WRITE:   oor_status = (ty_reg != FREE_TYPE) ? STAT_MISMATCH : STAT_OK;
            default:      oor_status = STAT_OK;
        endcase
    end

    // Status to the controller.
    always_comb
    begin
        stat.clr_last   = ptr_reg == LAST_C;
        stat.is_alloc   = kind_reg == KIND_ALLOC;
        stat.alloc_full = (used_reg >= DEPTH_C) || (nf_reg >= DEPTH_C);
        stat.need_scan  = used_inc < DEPTH_C;
        stat.in_range   = in_range;
        stat.scan_end   = ptr_reg >= DEPTH_C;
        stat.scan_hit   = !rd_data.used;
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

    // Memory access, counters and result staging.
    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = ptr_reg[AW-1:0];
        wr_data         = FREE_ENTRY;
        rd_en           = 1'b0;
        rd_addr         = slot_ext[AW-1:0];
        used_next       = used_reg;
        nf_next         = nf_reg;
        ptr_next        = ptr_reg;
        res_slot_next   = res_slot_reg;
        res_type_next   = res_type_reg;
        res_value_next  = res_value_reg;
        res_link_next   = res_link_reg;
        res_status_next = res_status_reg;

        // Clearing pass after reset, one entry a cycle.
        if (cmd.clr_wr)
        begin
            wr_en    = 1'b1;
            ptr_next = stat.clr_last ? '0 : ptr_reg + CW'(1);
        end

        if (cmd.exec)
        begin
            if (kind_reg == KIND_ALLOC)
            begin
                if (stat.alloc_full)
                begin
                    res_slot_next   = '0;
                    res_type_next   = '0;
                    res_value_next  = '0;
                    res_link_next   = 1'b0;
                    res_status_next = STAT_FULL;
                end
                else
                begin
                    // Claim the lowest free slot and start the scan above it.
                    wr_en           = 1'b1;
                    wr_addr         = nf_reg[AW-1:0];
                    wr_data         = '{used: 1'b1, etype: ty_reg, value: val_reg};
                    used_next       = used_inc;
                    nf_next         = DEPTH_C;
                    ptr_next        = nf_reg + CW'(1);
                    res_slot_next   = nf_ext[SLOT_W-1:0];
                    res_type_next   = ty_reg;
                    res_value_next  = val_reg;
                    res_link_next   = 1'b1;
                    res_status_next = STAT_OK;
                end
            end
            else if (in_range)
            begin
                rd_en = 1'b1;
            end
            else
            begin
                res_slot_next   = slot_reg;
                res_type_next   = FREE_TYPE;
                res_value_next  = '0;
                res_link_next   = 1'b0;
                res_status_next = oor_status;
            end
        end

        // Release, read or write on the entry just fetched.
        if (cmd.lookup)
        begin
            res_slot_next   = slot_reg;
            res_type_next   = rd_data.etype;
            res_value_next  = rd_data.value;
            res_link_next   = rd_data.used;
            res_status_next = STAT_OK;
            case (kind_reg)
                KIND_RELEASE:
                begin
                    if (!rd_data.used)
                    begin
                        res_status_next = STAT_FREE;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = slot_ext[AW-1:0];
                        wr_data        = FREE_ENTRY;
                        res_type_next  = FREE_TYPE;
                        res_value_next = '0;
                        res_link_next  = 1'b0;
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - CW'(1);
                        end
                        if (slot_below_nf)
                        begin
                            nf_next = slot_ext[CW-1:0];
                        end
                    end
                end
                KIND_WRITE:
                begin
                    wr_en          = 1'b1;
                    wr_addr        = slot_ext[AW-1:0];
                    wr_data        = '{used: rd_data.used, etype: rd_data.etype, value: val_reg};
                    res_value_next = val_reg;
                    if (ty_reg != rd_data.etype)
                    begin
                        res_status_next = STAT_MISMATCH;
                    end
                end
                default:
                begin
                    res_status_next = STAT_OK;
                end
            endcase
        end

        // Free-slot scan: fetch, then check.
        if (cmd.scan_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = ptr_reg[AW-1:0];
        end

        if (cmd.scan_chk)
        begin
            if (stat.scan_hit)
            begin
                nf_next = ptr_reg;
            end
            else
            begin
                ptr_next = ptr_reg + CW'(1);
            end
        end
    end

    // Output valid flag.
    always_comb
    begin
        if (cmd.push)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            nf_reg       <= '0;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            nf_reg       <= nf_next;
            ptr_reg      <= ptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            kind_reg <= kind_t'(s_tuser);
            slot_reg <= s_tdata[SLOT_W-1:0];
            ty_reg   <= s_tdata[SLOT_W +: TYPE_W];
            val_reg  <= s_tdata[SLOT_W + TYPE_W +: VALUE_W];
        end
        res_slot_reg   <= res_slot_next;
        res_type_reg   <= res_type_next;
        res_value_reg  <= res_value_next;
        res_link_reg   <= res_link_next;
        res_status_reg <= res_status_next;
        if (cmd.push)
        begin
            m_tdata_reg <= OUT_DATA_W'({LINK_W'(res_link_reg), res_value_reg,
                                        res_type_reg, res_slot_reg});
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== sv/rcsa_ctrl.sv =====
// Controller state machine: sequences clearing, operations and the free-slot scan.
`default_nettype none

module rcsa_ctrl
    import rcsa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_alloc)
                begin
                    state_next = (stat.alloc_full || !stat.need_scan) ? S_PUSH : S_SCAN_RD;
                end
                else
                begin
                    state_next = stat.in_range ? S_LOOKUP : S_PUSH;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_PUSH;
            end
            S_SCAN_RD:
            begin
                state_next = stat.scan_end ? S_PUSH : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                state_next = stat.scan_hit ? S_PUSH : S_SCAN_RD;
            end
            S_PUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands and handshake.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.take_in = s_tvalid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = !stat.scan_end;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
            end
            S_PUSH:
            begin
                cmd.push = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/refcount_slot_allocator.sv =====
// Top level of the reference-counted slot allocator.
//
// Requests enter on the s_ channel: s_tuser carries the operation (allocate, release,
// read, write), s_tdata the slot, type tag and value. Each request gives exactly one
// result on the m_ channel: m_tdata carries slot, type tag, value and link count after
// the operation, m_tuser the status (ok, table full, type mismatch, already free).
// One request is handled at a time. After acceptance, release, read and write on a slot
// inside the table issue the table read, act on the fetched entry, then load the output
// register; a slot beyond the table goes straight to the output. An allocate writes
// the lowest free slot and then scans upward for the next free one through the single
// table read port, with a read step and a check step per slot examined; a full
// table walk is the worst case. The next request is accepted in the cycle after
// the result is loaded. After reset the block sweeps the table to the free state,
// one entry a cycle, and holds s_tready low meanwhile. A result waits in the output
// register until taken; while m_tready is low the next request is still accepted
// and processed, and its result stays staged until the output register frees up.
`default_nettype none

module refcount_slot_allocator
    import rcsa_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // slot [9:0], entry_type [19:10], entry_value [51:20], zero fill [55:52]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  wire logic [KIND_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // result_slot [9:0], result_type [19:10], result_value [51:20],
    // link_count [59:52], zero fill [63:60]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]        m_tuser
);

    cmd_t  cmd;
    stat_t stat;

    rcsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rcsa_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== bench/rcsa_checker.sv =====
// Checker that predicts and compares every result of the reference-counted slot allocator.
`timescale 1ns / 100ps

module rcsa_checker
    import rcsa_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    // slot [9:0], entry_type [19:10], entry_value [51:20], zero fill [55:52]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  wire logic [KIND_W-1:0]     s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    // result_slot [9:0], result_type [19:10], result_value [51:20],
    // link_count [59:52], zero fill [63:60]
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    // status [1:0]
    input  wire logic [STATUS_W-1:0]   m_tuser,
    output int                         fail_count,
    output int                         pending
);

    // Expected content of one result.
    typedef struct packed {
        logic [SLOT_W-1:0]  rslot;
        logic [TYPE_W-1:0]  rtype;
        logic [VALUE_W-1:0] rvalue;
        logic [LINK_W-1:0]  links;
        status_t            status;
    } slot_result_t;

    // Shadow of the slot table and its bookkeeping.
    logic [LINK_W-1:0]  link_of  [DEPTH];
    logic [TYPE_W-1:0]  type_of  [DEPTH];
    logic [VALUE_W-1:0] value_of [DEPTH];
    int                 used_slots;
    int                 lowest_free;

    slot_result_t       slot_results [$];
    slot_result_t       oldest;
    int                 mismatches;

    // Report one field that differs from its expected value.
    task automatic compare_field(input string field, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Apply one accepted request to the shadow table and queue the result it must give.
    task automatic apply_table_op(input kind_t kind, input logic [SLOT_W-1:0] slot,
                                  input logic [TYPE_W-1:0] etype,
                                  input logic [VALUE_W-1:0] value);
        slot_result_t r;
        int           taken;
        int           i;
        r = '0;
        r.rslot = slot;
        r.status = STAT_OK;
        if (kind == KIND_ALLOC)
        begin
            if (used_slots >= DEPTH || lowest_free >= DEPTH)
            begin
                // A full table refuses the allocate and reports all-zero fields.
                r = '0;
                r.status = STAT_FULL;
            end
            else
            begin
                taken = lowest_free;
                link_of[taken] = 1;
                type_of[taken] = etype;
                value_of[taken] = value;
                used_slots++;
                // Look upward for the next free slot; none found leaves the pointer at the end.
                lowest_free = DEPTH;
                if (used_slots < DEPTH)
                begin
                    for (i = taken + 1; i < DEPTH; i++)
                    begin
                        if (link_of[i] == 0)
                        begin
                            lowest_free = i;
                            break;
                        end
                    end
                end
                r.rslot = SLOT_W'(taken);
                r.rtype = type_of[taken];
                r.rvalue = value_of[taken];
                r.links = link_of[taken];
            end
        end
        else if (int'(slot) >= DEPTH)
        begin
            // An address past the table looks like an empty free slot.
            r.rtype = FREE_TYPE;
            if (kind == KIND_RELEASE)
                r.status = STAT_FREE;
            else if (kind == KIND_WRITE && etype != FREE_TYPE)
                r.status = STAT_MISMATCH;
        end
        else
        begin
            if (kind == KIND_RELEASE)
            begin
                if (link_of[slot] == 0)
                    r.status = STAT_FREE;
                else
                begin
                    link_of[slot] = link_of[slot] - 1;
                    if (link_of[slot] == 0)
                    begin
                        type_of[slot] = FREE_TYPE;
                        value_of[slot] = '0;
                        if (used_slots > 0)
                            used_slots--;
                        if (lowest_free > int'(slot))
                            lowest_free = int'(slot);
                    end
                end
            end
            else if (kind == KIND_WRITE)
            begin
                // The value is written even when the type tag does not match.
                if (etype != type_of[slot])
                    r.status = STAT_MISMATCH;
                value_of[slot] = value;
            end
            r.rtype = type_of[slot];
            r.rvalue = value_of[slot];
            r.links = link_of[slot];
        end
        slot_results.push_back(r);
    endtask

    // Watch both channels: compare results first, then predict from the request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                link_of[i] = '0;
                type_of[i] = FREE_TYPE;
                value_of[i] = '0;
            end
            used_slots = 0;
            lowest_free = 0;
            mismatches = 0;
            slot_results.delete();
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (slot_results.size() == 0)
                begin
                    $display("%0t: result for slot 0x%0h arrived with no request outstanding",
                             $time, m_tdata[0 +: SLOT_W]);
                    mismatches++;
                end
                else
                begin
                    oldest = slot_results.pop_front();
                    compare_field("result_slot", oldest.rslot, m_tdata[0 +: SLOT_W]);
                    compare_field("result_type", oldest.rtype, m_tdata[SLOT_W +: TYPE_W]);
                    compare_field("result_value", oldest.rvalue,
                                  m_tdata[SLOT_W + TYPE_W +: VALUE_W]);
                    compare_field("link_count", oldest.links,
                                  m_tdata[SLOT_W + TYPE_W + VALUE_W +: LINK_W]);
                    compare_field("status", oldest.status, m_tuser);
                end
            end
            if (s_tvalid && s_tready)
                apply_table_op(kind_t'(s_tuser), s_tdata[0 +: SLOT_W],
                               s_tdata[SLOT_W +: TYPE_W], s_tdata[SLOT_W + TYPE_W +: VALUE_W]);
            pending <= slot_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top: drives requests into the slot allocator and gives the verdict.
`timescale 1ns / 100ps

module tb_top
    import rcsa_pkg::*;
;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    int                    fail_count;
    int                    pending;

    // Idle and stall rates in percent, changed from phase to phase.
    int                    send_idle_pct;
    int                    recv_stall_pct;

    // Occupancy as the allocator will see it, used to aim requests at live slots.
    logic                  slot_busy [DEPTH];
    int                    busy_count;

    refcount_slot_allocator #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    rcsa_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .fail_count(fail_count),
        .pending(pending)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: stall at the rate of the current phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Run limit for a hung block.
    initial
    begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Type tags: often a few fixed ones so that writes match, otherwise any tag.
    function automatic logic [TYPE_W-1:0] pick_type();
        if ($urandom_range(1) != 0)
            return TYPE_W'($urandom);
        case ($urandom_range(3))
            0: return FREE_TYPE;
            1: return '0;
            2: return TYPE_W'(1);
            default: return '1;
        endcase
    endfunction

    // Some slot in use, searched from a random start; any slot if the table is empty.
    function automatic logic [SLOT_W-1:0] pick_used_slot();
        int start;
        int n;
        int s;
        start = $urandom_range(DEPTH - 1);
        for (n = 0; n < DEPTH; n++)
        begin
            s = (start + n) % DEPTH;
            if (slot_busy[s])
                return SLOT_W'(s);
        end
        return SLOT_W'(start);
    endfunction

    // Send one request and wait until it is accepted.
    task automatic issue(input kind_t kind, input logic [SLOT_W-1:0] slot,
                         input logic [TYPE_W-1:0] etype, input logic [VALUE_W-1:0] value);
        int i;
        if (kind == KIND_ALLOC)
        begin
            for (i = 0; i < DEPTH; i++)
            begin
                if (!slot_busy[i])
                begin
                    slot_busy[i] = 1'b1;
                    busy_count++;
                    break;
                end
            end
        end
        else if (kind == KIND_RELEASE && slot_busy[slot])
        begin
            slot_busy[slot] = 1'b0;
            busy_count--;
        end
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= IN_DATA_W'({value, etype, slot});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // One random request; alloc_pct sets how often it is an allocate.
    task automatic random_request(input int alloc_pct);
        kind_t              kind;
        int                 roll;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        roll = $urandom_range(99);
        if (roll < alloc_pct)
            kind = KIND_ALLOC;
        else
        begin
            roll = $urandom_range(99);
            if (roll < 45)
                kind = KIND_RELEASE;
            else if (roll < 75)
                kind = KIND_WRITE;
            else
                kind = KIND_READ;
        end
        slot = ($urandom_range(3) == 0) ? SLOT_W'($urandom) : pick_used_slot();
        case ($urandom_range(7))
            0: value = '0;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'h8000_0000;
            3: value = '1;
            default: value = $urandom;
        endcase
        issue(kind, slot, pick_type(), value);
    endtask

    // Stop sending and wait until every outstanding request has its result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        busy_count = 0;
        for (int i = 0; i < DEPTH; i++)
            slot_busy[i] = 1'b0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= KIND_READ;
        m_tready <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: fresh table, extremes of the fields, all operations.
        issue(KIND_READ, '0, '0, '0);
        issue(KIND_READ, '1, '1, '1);
        issue(KIND_RELEASE, SLOT_W'(5), '0, '0);
        issue(KIND_WRITE, SLOT_W'(7), FREE_TYPE, 32'h1234_5678);
        issue(KIND_WRITE, SLOT_W'(8), '0, 32'h8000_0000);
        issue(KIND_ALLOC, '1, '0, 32'h7FFF_FFFF);
        issue(KIND_ALLOC, '0, '1, 32'h8000_0000);
        issue(KIND_ALLOC, SLOT_W'(9), FREE_TYPE, '1);
        issue(KIND_ALLOC, SLOT_W'(3), TYPE_W'(5), '0);
        issue(KIND_WRITE, SLOT_W'(1), '1, 32'd123);
        issue(KIND_WRITE, SLOT_W'(1), '0, '1);
        issue(KIND_READ, SLOT_W'(1), '0, '0);
        // Release to zero clears the slot; a second release finds it free.
        issue(KIND_RELEASE, SLOT_W'(1), '0, '0);
        issue(KIND_RELEASE, SLOT_W'(1), '0, '0);
        issue(KIND_READ, SLOT_W'(1), '0, '0);
        // The free pointer moves back down to a released slot.
        issue(KIND_ALLOC, '0, TYPE_W'(2), 32'hA5A5_5A5A);
        issue(KIND_RELEASE, SLOT_W'(3), '0, '0);
        issue(KIND_RELEASE, SLOT_W'(0), '0, '0);
        issue(KIND_ALLOC, '0, TYPE_W'(3), 32'h0000_0001);
        issue(KIND_ALLOC, '0, TYPE_W'(4), 32'hFFFF_FFFE);
        issue(KIND_WRITE, '1, FREE_TYPE, 32'h5555_AAAA);
        issue(KIND_WRITE, '1, TYPE_W'(1), 32'hAAAA_5555);
        issue(KIND_READ, '1, '0, '0);

        // Mixed traffic on a lightly used table, no idling.
        repeat (150) random_request(55);

        // Sender holds off until every result is back.
        drain_results();

        // Fill the table, then allocate into a full table and refill a single hole.
        send_idle_pct = 38;
        recv_stall_pct = 38;
        while (busy_count < DEPTH)
            issue(KIND_ALLOC, SLOT_W'($urandom), pick_type(), $urandom);
        repeat (3) issue(KIND_ALLOC, SLOT_W'($urandom), pick_type(), $urandom);
        issue(KIND_RELEASE, pick_used_slot(), '0, '0);
        repeat (2) issue(KIND_ALLOC, SLOT_W'($urandom), pick_type(), $urandom);

        // Mixed traffic on a crowded table under different idle patterns.
        send_idle_pct = 78;
        recv_stall_pct = 0;
        repeat (120) random_request(35);
        send_idle_pct = 0;
        recv_stall_pct = 78;
        repeat (120) random_request(35);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (100) random_request(35);

        // Let the last results drain, then watch for stray ones over a full scan time.
        drain_results();
        repeat (2 * DEPTH + 16) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rcsa_pkg.sv
sv/rcsa_table.sv
sv/rcsa_datapath.sv
sv/rcsa_ctrl.sv
sv/refcount_slot_allocator.sv
bench/rcsa_checker.sv
bench/tb_top.sv
